// ----- rtl/u2u_pkg.sv -----
`timescale 1ns / 1ps

package u2u_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam logic [1:0] LEN_ONE   = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd1;
    localparam logic [1:0] LEN_THREE = 2'd2;
    localparam logic [1:0] LEN_FOUR  = 2'd3;

    typedef struct packed {
        logic        has_second;
        logic [15:0] cp1;
        logic [20:0] cp0;
    } t_job;

    function automatic logic [1:0] enc_last(input logic [20:0] cp);
        logic [1:0] l;
        if (cp < 21'h80) begin
            l = LEN_ONE;
        end else if (cp < 21'h800) begin
            l = LEN_TWO;
        end else if (cp < SUPP_BASE) begin
            l = LEN_THREE;
        end else begin
            l = LEN_FOUR;
        end
        return l;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [1:0] l;
        logic [1:0] r;
        logic [7:0] b;
        l = enc_last(cp);
        r = l - idx;
        if (idx == 2'd0) begin
            unique case (l)
                LEN_ONE:   b = cp[7:0];
                LEN_TWO:   b = {3'b110, cp[10:6]};
                LEN_THREE: b = {4'b1110, cp[15:12]};
                default:   b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            unique case (r)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

// ----- rtl/utf16_to_utf8_transcoder_core.sv -----
// Flow: a code point completed by an accepted item is written into the job queue, then fetched
// into the back-end job register, then encoded into the output byte register.
// Throughput: one input byte per cycle while the job queue has room; results leave at
// one byte per cycle while pop is held and jobs are queued, set by the single byte encoder in the back end.
// Reset: synchronous active-low; clears pairing, held surrogate, queue and output.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_core #(
    parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_stream,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_big_endian
);

    logic          job_push;
    u2u_pkg::t_job front_job;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    u2u_pkg::t_job q_job;

    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    u2u_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (push && !q_full),
        .i_data_byte      (i_data_byte),
        .i_end_of_stream  (i_end_of_stream),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_big_endian (i_cfg_big_endian),
        .o_job_push       (job_push),
        .o_job            (front_job)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    u2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (q_empty),
        .i_job         (q_job),
        .o_job_pop     (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ----- rtl/u2u_front.sv -----
`timescale 1ns / 1ps

module u2u_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_stream,
    input  logic          i_cfg_write,
    input  logic          i_cfg_big_endian,
    output logic          o_job_push,
    output u2u_pkg::t_job o_job
);

    logic        r_big_endian;
    logic [7:0]  r_first_half;
    logic        r_half_valid;
    logic [15:0] r_held;
    logic        r_held_valid;

    logic [7:0]  n_first_half;
    logic        n_half_valid;
    logic [15:0] n_held;
    logic        n_held_valid;

    logic [15:0] unit;
    logic        is_hi;
    logic        is_lo;

    assign unit  = r_big_endian ? {r_first_half, i_data_byte} : {i_data_byte, r_first_half};
    assign is_hi = (unit[15:10] == u2u_pkg::HI_SURR_TAG);
    assign is_lo = (unit[15:10] == u2u_pkg::LO_SURR_TAG);

    always_comb begin
        n_first_half = r_first_half;
        n_half_valid = r_half_valid;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        o_job_push   = 1'b0;
        o_job        = '0;
        if (i_accept) begin
            if (!r_half_valid) begin
                if (i_end_of_stream) begin
                    // drop odd byte, flush held surrogate
                    o_job_push   = r_held_valid;
                    o_job.cp0    = {5'd0, r_held};
                    n_held_valid = 1'b0;
                end else begin
                    n_first_half = i_data_byte;
                    n_half_valid = 1'b1;
                end
            end else begin
                n_half_valid = 1'b0;
                if (r_held_valid) begin
                    n_held_valid = 1'b0;
                    o_job_push   = 1'b1;
                    if (is_lo) begin
                        o_job.cp0 = u2u_pkg::SUPP_BASE + {1'b0, r_held[9:0], unit[9:0]};
                    end else begin
                        o_job.cp0 = {5'd0, r_held};
                        if (is_hi && !i_end_of_stream) begin
                            n_held       = unit;
                            n_held_valid = 1'b1;
                        end else begin
                            o_job.has_second = 1'b1;
                            o_job.cp1        = unit;
                        end
                    end
                end else if (is_hi && !i_end_of_stream) begin
                    n_held       = unit;
                    n_held_valid = 1'b1;
                end else begin
                    o_job_push = 1'b1;
                    o_job.cp0  = {5'd0, unit};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_half_valid <= 1'b0;
            r_held_valid <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                r_big_endian <= i_cfg_big_endian;
            end
            r_half_valid <= n_half_valid;
            r_held_valid <= n_held_valid;
        end
        r_first_half <= n_first_half;
        r_held       <= n_held;
    end

endmodule

// ----- rtl/u2u_queue.sv -----
`timescale 1ns / 1ps

module u2u_queue #(
    parameter int DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u2u_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output u2u_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- rtl/u2u_back.sv -----
`timescale 1ns / 1ps

module u2u_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  u2u_pkg::t_job i_job,
    output logic          o_job_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run
);

    u2u_pkg::t_job r_job;
    logic          r_job_valid;
    logic          r_sel;
    logic [1:0]    r_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [20:0] cur_cp;
    logic [1:0]  cur_last;
    logic        last_in_cp;
    logic        job_end;
    logic        load;
    logic        fetch;

    assign cur_cp     = r_sel ? {5'd0, r_job.cp1} : r_job.cp0;
    assign cur_last   = u2u_pkg::enc_last(cur_cp);
    assign last_in_cp = (r_idx == cur_last);
    assign job_end    = last_in_cp && (r_sel || !r_job.has_second);
    assign load       = r_job_valid && (!r_out_valid || i_pop);
    assign fetch      = !i_job_empty && (!r_job_valid || (load && job_end));
    assign o_job_pop  = fetch;

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_sel       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fetch) begin
                r_job_valid <= 1'b1;
                r_sel       <= 1'b0;
                r_idx       <= '0;
            end else if (load) begin
                if (job_end) begin
                    r_job_valid <= 1'b0;
                end else if (last_in_cp) begin
                    r_sel <= 1'b1;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (fetch) begin
            r_job <= i_job;
        end
        if (load) begin
            r_out_byte <= u2u_pkg::enc_byte(cur_cp, r_idx);
            r_out_last <= job_end;
        end
    end

endmodule

// ----- rtl/u2u_checker.sv -----
`timescale 1ns / 1ps

module u2u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("output or input side not idle after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_last_of_run)))
        else $error("waiting result changed");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_run) |=> !empty)
        else $error("run broken before its last item");

    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_byte[7:6] == 2'b11) |-> !o_last_of_run)
        else $error("multi-byte lead marked last");

    a_lead_then_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_out_byte[7:6] == 2'b11) |=> (!empty && o_out_byte[7:6] == 2'b10))
        else $error("lead byte not followed by continuation");

endmodule

bind utf16_to_utf8_transcoder_core u2u_checker u_u2u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

// ----- test/utf16_to_utf8_transcoder_core_test.sv -----
`timescale 1ns / 1ps

class transcode_board;
    bit          big_endian;
    logic [7:0]  first_half;
    bit          half_valid;
    logic [15:0] held_high;
    bit          held_valid;
    logic [7:0]  run_bytes[$];
    logic [8:0]  utf8_expected[$];
    int          errors;

    function new();
        big_endian = 1'b0;
        first_half = 8'h00;
        half_valid = 1'b0;
        held_high  = 16'h0000;
        held_valid = 1'b0;
        errors     = 0;
    endfunction

    function void set_order(bit be);
        big_endian = be;
    endfunction

    function void put_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            run_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            run_bytes.push_back({3'b110, cp[10:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            run_bytes.push_back({4'b1110, cp[15:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            run_bytes.push_back({5'b11110, cp[20:18]});
            run_bytes.push_back({2'b10, cp[17:12]});
            run_bytes.push_back({2'b10, cp[11:6]});
            run_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function void note_byte(logic [7:0] b, bit eos);
        logic [15:0] unit;
        bit          paired;
        run_bytes.delete();
        paired = 1'b0;
        if (!half_valid) begin
            if (eos) begin
                if (held_valid) put_point({5'd0, held_high});
                held_valid = 1'b0;
                held_high  = 16'h0000;
            end else begin
                first_half = b;
                half_valid = 1'b1;
            end
        end else begin
            unit       = big_endian ? {first_half, b} : {b, first_half};
            half_valid = 1'b0;
            first_half = 8'h00;
            if (held_valid) begin
                if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                    put_point(21'h10000 + {held_high[9:0], unit[9:0]});
                    paired = 1'b1;
                end else begin
                    put_point({5'd0, held_high});
                end
                held_valid = 1'b0;
                held_high  = 16'h0000;
            end
            if (!paired) begin
                if (unit >= 16'hD800 && unit <= 16'hDBFF && !eos) begin
                    held_high  = unit;
                    held_valid = 1'b1;
                end else begin
                    put_point({5'd0, unit});
                end
            end
        end
        for (int k = 0; k < run_bytes.size(); k++) begin
            utf8_expected.push_back({k == run_bytes.size() - 1, run_bytes[k]});
        end
    endfunction

    function void check_byte(logic [7:0] b, logic last);
        logic [8:0] exp_item;
        if (utf8_expected.size() == 0) begin
            $display("%0t: unexpected item: out_byte %h last_of_run %b", $time, b, last);
            errors++;
        end else begin
            exp_item = utf8_expected.pop_front();
            if (b !== exp_item[7:0]) begin
                $display("%0t: out_byte expected %h actual %h", $time, exp_item[7:0], b);
                errors++;
            end
            if (last !== exp_item[8]) begin
                $display("%0t: last_of_run expected %b actual %b", $time, exp_item[8], last);
                errors++;
            end
        end
    endfunction

    function int pending();
        return utf8_expected.size();
    endfunction
endclass

module utf16_to_utf8_transcoder_core_test;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       i_end_of_stream;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_big_endian;

    transcode_board board = new();
    int  stall_cycles = 0;
    int  send_gap_pct = 0;
    int  pop_stall_pct = 0;
    bit  cur_be = 1'b0;
    bit  took;

    utf16_to_utf8_transcoder_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_end_of_stream  (i_end_of_stream),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_big_endian (i_cfg_big_endian)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took = 1'b0;
            if (push && !full) begin
                board.note_byte(i_data_byte, i_end_of_stream);
                took = 1'b1;
            end
            if (pop && !empty) begin
                board.check_byte(o_out_byte, o_last_of_run);
                took = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                board.set_order(i_cfg_big_endian);
                took = 1'b1;
            end
            stall_cycles <= took ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress, giving up", $time);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, bit eos);
        while ($urandom_range(99) < send_gap_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push            = 1'b1;
        i_data_byte     = b;
        i_end_of_stream = eos;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_unit(logic [15:0] u, bit eos);
        if (cur_be) begin
            send_byte(u[15:8], 1'b0);
            send_byte(u[7:0], eos);
        end else begin
            send_byte(u[7:0], 1'b0);
            send_byte(u[15:8], eos);
        end
    endtask

    task automatic settle();
        push = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_order(bit be);
        i_cfg_valid      = 1'b1;
        i_cfg_big_endian = be;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_be      = be;
    endtask

    task automatic random_phase(int n_bytes);
        int          sent;
        int          pick;
        logic [15:0] u;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_unit(16'($urandom_range(16'h7F)), $urandom_range(99) < 5);
                sent += 2;
            end else if (pick < 40) begin
                send_unit(16'($urandom_range(16'h7FF, 16'h80)), $urandom_range(99) < 5);
                sent += 2;
            end else if (pick < 55) begin
                u = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h800))
                                      : 16'($urandom_range(16'hFFFF, 16'hE000));
                send_unit(u, $urandom_range(99) < 5);
                sent += 2;
            end else if (pick < 75) begin
                send_unit(16'(16'hD800 + $urandom_range(16'h3FF)), 1'b0);
                send_unit(16'(16'hDC00 + $urandom_range(16'h3FF)), $urandom_range(99) < 5);
                sent += 4;
            end else if (pick < 82) begin
                send_unit(16'(16'hDC00 + $urandom_range(16'h3FF)), 1'b0);
                sent += 2;
            end else if (pick < 88) begin
                send_unit(16'(16'hD800 + $urandom_range(16'h3FF)), $urandom_range(99) < 15);
                sent += 2;
            end else if (pick < 94) begin
                send_unit(16'($urandom_range(16'hFFFF)), $urandom_range(99) < 10);
                sent += 2;
            end else begin
                send_byte(8'($urandom_range(8'hFF)), 1'b1);
                sent += 1;
            end
        end
    endtask

    task automatic run_phase(bit be, int gap, int stall);
        settle();
        write_order(be);
        send_gap_pct  = gap;
        pop_stall_pct = stall;
        random_phase(50);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        push             = 1'b0;
        i_data_byte      = 8'h00;
        i_end_of_stream  = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_big_endian = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_order(1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'hDE00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hD801, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_unit(16'hDBFF, 1'b1);
        send_byte(8'h5A, 1'b1);

        // flip byte order with half a unit stored
        send_byte(8'h20, 1'b0);
        settle();
        write_order(1'b1);
        send_byte(8'h00, 1'b0);

        run_phase(1'b1, 0, 0);
        run_phase(1'b0, 48, 0);
        run_phase(1'b1, 0, 48);
        run_phase(1'b0, 7, 7);

        settle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
